// ----- sv/mpwm_pkg.sv -----
`timescale 1ns / 1ps

package mpwm_pkg;

	// phase period in permille steps
	localparam int unsigned PERIOD = 1000;

	// field and register widths
	localparam int unsigned PHASE_W    = 10;
	localparam int unsigned DUTY_W     = 10;
	localparam int unsigned CHAN_W     = 4;
	localparam int unsigned TICK_W     = 16;
	localparam int unsigned COUNT_W    = 4;
	localparam int unsigned STEP_W     = 10;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned PINS_W     = 8;
	// product of a channel index (below 16) and a step value
	localparam int unsigned PROD_W     = 15;

	// command codes
	localparam logic CMD_TICK     = 1'b0;
	localparam logic CMD_SET_DUTY = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_STEP   = 2'd2;

	// configuration seen by the datapath
	typedef struct packed {
		logic [TICK_W-1:0]  tick_length;
		logic [COUNT_W-1:0] channel_count;
	} cfg_t;

	// reduce a product modulo the period: coarse quotient by a shift, then one correction
	function automatic logic [PHASE_W-1:0] mod_period(input logic [PROD_W-1:0] x);
		logic [4:0]  q;
		logic [15:0] r;
		q = x[PROD_W-1:10];
		r = {1'b0, x} - ({11'd0, q} * 16'(PERIOD));
		if (r >= 16'(PERIOD)) begin
			r = r - 16'(PERIOD);
		end
		return r[PHASE_W-1:0];
	endfunction

endpackage

// ----- sv/mpwm_cfg.sv -----
`timescale 1ns / 1ps

module mpwm_cfg
	import mpwm_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	output cfg_t                    cfg,
	output logic [PHASE_W-1:0]      offset [LANES]
);

	logic [TICK_W-1:0]  tick_length_q;
	logic [COUNT_W-1:0] channel_count_q;

	// plain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_length_q   <= 16'd1;
			channel_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_LENGTH:   tick_length_q   <= cfg_wdata[TICK_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.tick_length   = tick_length_q;
	assign cfg.channel_count = channel_count_q;

	// per-channel stagger, reduced modulo the period when the step is written
	for (genvar i = 0; i < LANES; i++) begin : g_off
		logic [PROD_W-1:0]  prod;
		logic [PHASE_W-1:0] off_q;

		assign prod = PROD_W'(i) * {5'd0, cfg_wdata[STEP_W-1:0]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				off_q <= '0;
			end else if (cfg_we && (cfg_index == REG_OFFSET_STEP)) begin
				off_q <= mod_period(prod);
			end
		end

		assign offset[i] = off_q;
	end

endmodule

// ----- sv/mpwm_lane.sv -----
`timescale 1ns / 1ps

module mpwm_lane
	import mpwm_pkg::*;
(
	input  logic               enable,
	input  logic [PHASE_W-1:0] phase,
	input  logic [PHASE_W-1:0] offset,
	input  logic [DUTY_W-1:0]  duty,
	output logic               level
);

	logic [PHASE_W:0]   sum;
	logic [PHASE_W-1:0] pos;

	// staggered position, both terms below the period
	always_comb begin
		sum = {1'b0, phase} + {1'b0, offset};
		if (sum >= 11'(PERIOD)) begin
			sum = sum - 11'(PERIOD);
		end
		pos = sum[PHASE_W-1:0];
	end

	assign level = enable && (pos < duty);

endmodule

// ----- sv/multichannel_permille_pwm.sv -----
`timescale 1ns / 1ps

// Multichannel PWM with duty in permille.
// Input stream (s_*): each transaction is either a millisecond tick
// (s_tuser = 0) or a duty write (s_tuser = 1) for the channel and duty in
// s_tdata. Every input transaction gives exactly one output transaction.
// Output stream (m_*): m_tdata carries the pin levels of channels 0..7,
// m_tuser is set when that tick advanced the shared phase.
// Configuration: cfg_we with cfg_index selects tick length (0), channel
// count (1) or stagger step (2); write only while no transaction is in
// flight. The stagger step is reduced per channel when it is written.
// Each transaction passes the input register and then the result register.
// Throughput: one transaction per cycle while the output is not stalled; the
// path from the phase increment through the per-channel position and duty
// compare into the result register is combinational.
// Reset clears the prescale count, phase, duty store and pins; tick length
// returns to 1, channel count and step to 0.
// When m_tready is low the result is held; if the input register is empty, one
// more transaction is taken into it, after which s_tready drops until the result leaves.

module multichannel_permille_pwm
	import mpwm_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // channel[3:0], duty[13:4], zero fill
	input  logic                  s_tuser,   // command
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // pin_levels[7:0]
	output logic                  m_tuser    // stepped
);

	localparam int LANES = (CHANNELS < PINS_W) ? CHANNELS : PINS_W;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_t               cfg;
	logic [PHASE_W-1:0] offset [LANES];

	// input register
	logic               valid_s1;
	logic               cmd_s1;
	logic [CHAN_W-1:0]  channel_s1;
	logic [DUTY_W-1:0]  duty_s1;

	// result register
	logic               m_valid_s2;
	logic [PINS_W-1:0]  pins_s2;
	logic               stepped_s2;

	// block state
	logic [TICK_W-1:0]  prescale_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PINS_W-1:0]  pin_q;
	logic [DUTY_W-1:0]  duty_q [CHANNELS];

	logic               advance;
	logic               do_step;
	logic [TICK_W-1:0]  pc_inc;
	logic [PHASE_W-1:0] phase_next;
	logic [PINS_W-1:0]  levels;
	logic [PINS_W-1:0]  pin_next;
	logic [DUTY_W-1:0]  duty_clamped;
	logic               chan_ok;

	mpwm_cfg #(
		.LANES (LANES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.offset    (offset)
	);

	// handshake: the pipeline moves when the result register is free
	assign advance  = !m_valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1     <= s_tuser;
			channel_s1 <= s_tdata[CHAN_W-1:0];
			duty_s1    <= s_tdata[CHAN_W+DUTY_W-1:CHAN_W];
		end
	end

	// tick and phase arithmetic
	always_comb begin
		pc_inc       = prescale_q + 16'd1;
		do_step      = valid_s1 && (cmd_s1 == CMD_TICK) && (pc_inc >= cfg.tick_length);
		phase_next   = (phase_q == PHASE_W'(PERIOD - 1)) ? '0 : phase_q + 10'd1;
		pin_next     = do_step ? levels : pin_q;
		duty_clamped = (duty_s1 > DUTY_W'(PERIOD)) ? DUTY_W'(PERIOD) : duty_s1;
		chan_ok      = ({1'b0, channel_s1} < 5'(CHANNELS));
	end

	// channel compare lanes, visible channels only
	for (genvar i = 0; i < PINS_W; i++) begin : g_lane
		if (i < LANES) begin : g_on
			mpwm_lane u_lane (
				.enable (5'(i) < {1'b0, cfg.channel_count}),
				.phase  (phase_next),
				.offset (offset[i]),
				.duty   (duty_q[i]),
				.level  (levels[i])
			);
		end else begin : g_off
			assign levels[i] = 1'b0;
		end
	end

	// state update for the transaction in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			phase_q    <= '0;
			pin_q      <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				duty_q[k] <= '0;
			end
		end else if (valid_s1 && advance) begin
			if (cmd_s1 == CMD_TICK) begin
				if (do_step) begin
					prescale_q <= '0;
					phase_q    <= phase_next;
					pin_q      <= levels;
				end else begin
					prescale_q <= pc_inc;
				end
			end else if (chan_ok) begin
				duty_q[channel_s1[IDX_W-1:0]] <= duty_clamped;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (advance) begin
			m_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pins_s2    <= pin_next;
			stepped_s2 <= do_step;
		end
	end

	assign m_tvalid = m_valid_s2;
	assign m_tdata  = pins_s2;
	assign m_tuser  = stepped_s2;

	// phase stays inside the period
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PHASE_W'(PERIOD))
		else $error("phase out of range");

	// a pending result always matches the held pin state
	a_pins_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_s2 |-> (pins_s2 == pin_q))
		else $error("result pins differ from pin state");

	// a stepped result leaves the prescale count cleared
	a_step_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_s2 && stepped_s2) |-> (prescale_q == '0))
		else $error("prescale not cleared after step");

	// a stalled transaction stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(cmd_s1) && $stable(channel_s1)))
		else $error("input register lost a stalled transaction");

endmodule
